FILE: hw/rtl/gcb_pkg.sv
// Package for the glyph coverage blend block: register codes, widths and blend masks.
// Used by gcb_blend and glyph_coverage_blend; depends on nothing.
package gcb_pkg;

    localparam int MAX_DIM = 4096;
    localparam int CNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_W = 13;
    localparam int CMP_W = (CNT_W + 1 > DIM_W) ? CNT_W + 1 : DIM_W;
    localparam int PITCH_W = 16;
    localparam int PIX_W = 32;
    localparam int COV_W = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [PIX_W-1:0] RB_MASK = 32'h00FF00FF;
    localparam logic [PIX_W-1:0] G_MASK = 32'h0000FF00;
    localparam logic [PIX_W-1:0] A_MASK = 32'hFF000000;
    localparam logic [COV_W-1:0] COV_MAX = 8'hFF;
    localparam logic [15:0] ROUND_BIAS = 16'd128;

    localparam logic [DIM_W-1:0] DIM_RESET = 13'd1;
    localparam logic [CMP_W-1:0] DIM_LIMIT = CMP_W'(MAX_DIM);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FILL_COLOR  = 3'd0,
        REG_ROW_PITCH   = 3'd1,
        REG_RECT_WIDTH  = 3'd2,
        REG_RECT_HEIGHT = 3'd3,
        REG_BLEND_MODE  = 3'd4
    } t_cfg_reg;

    typedef enum logic {
        MODE_PACKED  = 1'b0,
        MODE_ROUNDED = 1'b1
    } t_blend_mode;

    // A size of zero counts as one and a size above the limit as the limit.
    function automatic logic [CMP_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(v);
        if (v == '0) begin
            return CMP_W'(1);
        end else if (ext > DIM_LIMIT) begin
            return DIM_LIMIT;
        end
        return ext;
    endfunction

endpackage

FILE: hw/rtl/glyph_coverage_blend.sv
// Top level of the glyph coverage blend: configuration registers, raster counters,
// a two-stage pixel pipeline and assertions. Depends on gcb_pkg and gcb_blend.
// The input register holds an accepted word until the output register can take it;
// they form the two stages. Throughput: one word per cycle unless the output stalls.
// Reset clears valids, raster counters and config registers; width and height go to 1.
module glyph_coverage_blend (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [gcb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [gcb_pkg::COV_W-1:0]     i_coverage,
    input  logic [gcb_pkg::PIX_W-1:0]     i_old_pixel,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [gcb_pkg::PIX_W-1:0]     o_new_pixel,
    output logic [31:0]                   o_pixel_offset,
    output logic                          o_row_end,
    output logic                          o_rect_end
);

    logic [gcb_pkg::PIX_W-1:0]   r_fill_color;
    logic [gcb_pkg::PITCH_W-1:0] r_row_pitch;
    logic [gcb_pkg::DIM_W-1:0]   r_rect_width, r_rect_height;
    gcb_pkg::t_blend_mode        r_blend_mode;

    logic [gcb_pkg::CNT_W-1:0] r_col, r_row, n_col, n_row;
    logic r_s1_valid, n_s1_valid, r_out_valid, n_out_valid;

    logic [gcb_pkg::COV_W-1:0] r_s1_cov;
    logic [gcb_pkg::PIX_W-1:0] r_s1_old;
    logic [gcb_pkg::CNT_W-1:0] r_s1_col, r_s1_row;
    logic r_s1_rend, r_s1_xend;

    logic [gcb_pkg::PIX_W-1:0] r_out_pixel, blend_pix;
    logic [31:0] r_out_offset, offset;
    logic r_out_rend, r_out_xend;

    logic [gcb_pkg::CMP_W-1:0] dim_w, dim_h, col_next, row_next;
    logic rend, xend, in_fire, s1_move, out_stall;
    logic [gcb_pkg::CNT_W+gcb_pkg::PITCH_W-1:0] row_prod;
    gcb_pkg::t_cfg_reg cfg_reg;

    assign o_cfg_ready = 1'b1;
    assign cfg_reg = gcb_pkg::t_cfg_reg'(i_cfg_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_color <= '0;
            r_row_pitch <= '0;
            r_rect_width <= gcb_pkg::DIM_RESET;
            r_rect_height <= gcb_pkg::DIM_RESET;
            r_blend_mode <= gcb_pkg::MODE_PACKED;
        end else if (i_cfg_valid) begin
            unique case (cfg_reg)
                gcb_pkg::REG_FILL_COLOR:  r_fill_color <= i_cfg_data;
                gcb_pkg::REG_ROW_PITCH:   r_row_pitch <= i_cfg_data[gcb_pkg::PITCH_W-1:0];
                gcb_pkg::REG_RECT_WIDTH:  r_rect_width <= i_cfg_data[gcb_pkg::DIM_W-1:0];
                gcb_pkg::REG_RECT_HEIGHT: r_rect_height <= i_cfg_data[gcb_pkg::DIM_W-1:0];
                gcb_pkg::REG_BLEND_MODE:  r_blend_mode <= gcb_pkg::t_blend_mode'(i_cfg_data[0]);
                default: ;
            endcase
        end
    end

    assign out_stall = r_out_valid && !i_out_ready;
    assign s1_move = r_s1_valid && !out_stall;
    assign o_in_ready = !r_s1_valid || !out_stall;
    assign in_fire = i_in_valid && o_in_ready;

    assign dim_w = gcb_pkg::clamp_dim(r_rect_width);
    assign dim_h = gcb_pkg::clamp_dim(r_rect_height);
    assign col_next = gcb_pkg::CMP_W'(r_col) + gcb_pkg::CMP_W'(1);
    assign row_next = gcb_pkg::CMP_W'(r_row) + gcb_pkg::CMP_W'(1);
    assign rend = col_next >= dim_w;
    assign xend = rend && (row_next >= dim_h);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (in_fire) begin
            if (xend) begin
                n_col = '0;
                n_row = '0;
            end else if (rend) begin
                n_col = '0;
                n_row = r_row + gcb_pkg::CNT_W'(1);
            end else begin
                n_col = r_col + gcb_pkg::CNT_W'(1);
            end
        end
        n_s1_valid = in_fire || (r_s1_valid && !s1_move);
        n_out_valid = s1_move || out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_s1_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_s1_valid <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_cov <= i_coverage;
            r_s1_old <= i_old_pixel;
            r_s1_col <= r_col;
            r_s1_row <= r_row;
            r_s1_rend <= rend;
            r_s1_xend <= xend;
        end
    end

    gcb_blend u_blend (
        .i_fill  (r_fill_color),
        .i_old   (r_s1_old),
        .i_cov   (r_s1_cov),
        .i_mode  (r_blend_mode),
        .o_pixel (blend_pix)
    );

    assign row_prod = r_s1_row * r_row_pitch;
    assign offset = 32'(row_prod) + {30'(r_s1_col), 2'b00};

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_pixel <= blend_pix;
            r_out_offset <= offset;
            r_out_rend <= r_s1_rend;
            r_out_xend <= r_s1_xend;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_new_pixel = r_out_pixel;
    assign o_pixel_offset = r_out_offset;
    assign o_row_end = r_out_rend;
    assign o_rect_end = r_out_xend;

    a_rect_end_is_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rect_end |-> o_row_end)
        else $error("rect end without row end");

    a_counters_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && xend |=> (r_col == '0) && (r_row == '0))
        else $error("raster counters did not return to zero at rectangle end");

    a_stage_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && out_stall |=> r_s1_valid && r_out_valid)
        else $error("pipeline word dropped during output stall");

    a_ready_low_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_s1_valid && r_out_valid)
        else $error("input stalled while a stage is free");

endmodule

FILE: hw/rtl/gcb_blend.sv
// Blend datapath: packed red/blue and green blend, or rounded four-channel blend.
// Uses constants and types from gcb_pkg.
module gcb_blend (
    input  logic [gcb_pkg::PIX_W-1:0] i_fill,
    input  logic [gcb_pkg::PIX_W-1:0] i_old,
    input  logic [gcb_pkg::COV_W-1:0] i_cov,
    input  gcb_pkg::t_blend_mode      i_mode,
    output logic [gcb_pkg::PIX_W-1:0] o_pixel
);

    logic [gcb_pkg::PIX_W-1:0] rb_d, g_d, rb_diff, g_diff, rb_sum, g_sum;
    logic [gcb_pkg::PIX_W+gcb_pkg::COV_W-1:0] rb_prod, g_prod;
    logic [gcb_pkg::PIX_W-1:0] packed_pix, rounded_pix;
    logic [gcb_pkg::COV_W-1:0] inv_cov;

    assign rb_d = i_old & gcb_pkg::RB_MASK;
    assign g_d = i_old & gcb_pkg::G_MASK;
    assign rb_diff = (i_fill & gcb_pkg::RB_MASK) - rb_d;
    assign g_diff = (i_fill & gcb_pkg::G_MASK) - g_d;
    assign rb_prod = rb_diff * i_cov;
    assign g_prod = g_diff * i_cov;
    assign rb_sum = rb_d + {8'b0, rb_prod[31:8]};
    assign g_sum = g_d + {8'b0, g_prod[31:8]};
    assign packed_pix = (i_fill & gcb_pkg::A_MASK) | (rb_sum & gcb_pkg::RB_MASK)
                      | (g_sum & gcb_pkg::G_MASK);

    assign inv_cov = gcb_pkg::COV_MAX - i_cov;

    always_comb begin
        logic [7:0]  c, e;
        logic [15:0] v;
        logic [24:0] w;
        rounded_pix = '0;
        for (int lane = 0; lane < 4; lane++) begin
            c = i_fill[lane*8 +: 8];
            e = i_old[lane*8 +: 8];
            v = (c * i_cov) + (e * inv_cov) + gcb_pkg::ROUND_BIAS;
            w = {1'b0, v, 8'b0} + {9'b0, v};
            rounded_pix[lane*8 +: 8] = w[24] ? 8'hFF : w[23:16];
        end
    end

    always_comb begin
        case (i_mode)
            gcb_pkg::MODE_ROUNDED: o_pixel = rounded_pix;
            default:               o_pixel = packed_pix;
        endcase
    end

endmodule

FILE: test/tb_glyph_coverage_blend.sv
`timescale 1ns / 100ps
// Self-checking testbench for glyph_coverage_blend: a directed table, then random pixels and
// register settings under three flow-control phases. Depends on gcb_pkg and the block's RTL.
module tb_glyph_coverage_blend;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_WORDS = 567;
    localparam logic [gcb_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [gcb_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [31:0] px;
        logic [31:0] off;
        logic        rend;
        logic        xend;
    } t_blend_out;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_PIX,
        ROW_PIX_TYPED
    } t_row_kind;

    typedef struct packed {
        t_row_kind                     kind;
        logic [gcb_pkg::CFG_IDX_W-1:0] index;
        logic [31:0]                   data;
        logic [gcb_pkg::COV_W-1:0]     cov;
        t_blend_out                    res;
    } t_stim_row;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [gcb_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]                   i_cfg_data;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic [gcb_pkg::COV_W-1:0]     i_coverage;
    logic [gcb_pkg::PIX_W-1:0]     i_old_pixel;
    logic                          o_out_valid;
    logic                          i_out_ready;
    logic [gcb_pkg::PIX_W-1:0]     o_new_pixel;
    logic [31:0]                   o_pixel_offset;
    logic                          o_row_end;
    logic                          o_rect_end;

    glyph_coverage_blend dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_coverage     (i_coverage),
        .i_old_pixel    (i_old_pixel),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_new_pixel    (o_new_pixel),
        .o_pixel_offset (o_pixel_offset),
        .o_row_end      (o_row_end),
        .o_rect_end     (o_rect_end)
    );

    // Shadow copy of the registers and the raster position.
    logic [31:0]                 fill_q = '0;
    logic [gcb_pkg::PITCH_W-1:0] pitch_q = '0;
    logic [gcb_pkg::DIM_W-1:0]   width_q = gcb_pkg::DIM_RESET;
    logic [gcb_pkg::DIM_W-1:0]   height_q = gcb_pkg::DIM_RESET;
    gcb_pkg::t_blend_mode        mode_q = gcb_pkg::MODE_PACKED;
    logic [gcb_pkg::CNT_W-1:0]   col_q = '0;
    logic [gcb_pkg::CNT_W-1:0]   row_q = '0;

    t_blend_out due_pixels[$];
    t_stim_row  dir_rows[$];

    int in_idle_pct = 0;
    int out_idle_pct = 0;
    int cycle_cnt = 0;
    int err_cnt = 0;
    int sent_cnt = 0;
    int checked_cnt = 0;
    int row_ends = 0;
    int rect_ends = 0;
    int reg_writes = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end

    function automatic logic [gcb_pkg::CMP_W-1:0] clamp_size(
        input logic [gcb_pkg::DIM_W-1:0] v);
        if (v == '0) begin
            return gcb_pkg::CMP_W'(1);
        end
        if (gcb_pkg::CMP_W'(v) > gcb_pkg::CMP_W'(gcb_pkg::MAX_DIM)) begin
            return gcb_pkg::CMP_W'(gcb_pkg::MAX_DIM);
        end
        return gcb_pkg::CMP_W'(v);
    endfunction

    function automatic logic [31:0] packed_blend(input logic [31:0] s, input logic [31:0] d,
                                                 input logic [7:0] a);
        logic [31:0] rb;
        logic [31:0] g;
        rb = d & gcb_pkg::RB_MASK;
        g = d & gcb_pkg::G_MASK;
        rb = rb + ((((s & gcb_pkg::RB_MASK) - rb) * 32'(a)) >> 8);
        g = g + ((((s & gcb_pkg::G_MASK) - g) * 32'(a)) >> 8);
        return (s & gcb_pkg::A_MASK) | (rb & gcb_pkg::RB_MASK) | (g & gcb_pkg::G_MASK);
    endfunction

    function automatic logic [31:0] rounded_blend(input logic [31:0] s, input logic [31:0] d,
                                                  input logic [7:0] a);
        logic [31:0] res;
        logic [31:0] v;
        logic [31:0] q;
        res = '0;
        for (int k = 0; k < 4; k++) begin
            v = 32'(s[8*k +: 8]) * 32'(a) + 32'(d[8*k +: 8]) * (32'd255 - 32'(a)) + 32'd128;
            v = v & 32'h0000FFFF;
            q = (v * 32'd257) >> 16;
            if (q > 32'd255) begin
                q = 32'd255;
            end
            res[8*k +: 8] = q[7:0];
        end
        return res;
    endfunction

    // Result for the pixel at the current raster position; moves the position on.
    function automatic t_blend_out blend_at_cursor(input logic [7:0] a, input logic [31:0] d);
        t_blend_out r;
        logic [gcb_pkg::CMP_W-1:0] w;
        logic [gcb_pkg::CMP_W-1:0] h;
        w = clamp_size(width_q);
        h = clamp_size(height_q);
        r.px = (mode_q == gcb_pkg::MODE_ROUNDED) ? rounded_blend(fill_q, d, a)
                                                 : packed_blend(fill_q, d, a);
        r.off = 32'(row_q) * 32'(pitch_q) + (32'(col_q) << 2);
        r.rend = (gcb_pkg::CMP_W'(col_q) + gcb_pkg::CMP_W'(1)) >= w;
        r.xend = r.rend && ((gcb_pkg::CMP_W'(row_q) + gcb_pkg::CMP_W'(1)) >= h);
        if (r.xend) begin
            col_q = '0;
            row_q = '0;
        end else if (r.rend) begin
            col_q = '0;
            row_q = row_q + gcb_pkg::CNT_W'(1);
        end else begin
            col_q = col_q + gcb_pkg::CNT_W'(1);
        end
        return r;
    endfunction

    function automatic void apply_reg(input logic [gcb_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [31:0] data);
        case (idx)
            gcb_pkg::REG_FILL_COLOR:  fill_q = data;
            gcb_pkg::REG_ROW_PITCH:   pitch_q = data[gcb_pkg::PITCH_W-1:0];
            gcb_pkg::REG_RECT_WIDTH:  width_q = data[gcb_pkg::DIM_W-1:0];
            gcb_pkg::REG_RECT_HEIGHT: height_q = data[gcb_pkg::DIM_W-1:0];
            gcb_pkg::REG_BLEND_MODE:  mode_q = gcb_pkg::t_blend_mode'(data[0]);
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_blend_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_pixels.size() == 0) begin
                $error("unexpected word: new_pixel %h, pixel_offset %h", o_new_pixel,
                       o_pixel_offset);
                err_cnt++;
            end else begin
                want = due_pixels.pop_front();
                if (o_new_pixel !== want.px) begin
                    $error("new_pixel: expected %h, got %h", want.px, o_new_pixel);
                    err_cnt++;
                end
                if (o_pixel_offset !== want.off) begin
                    $error("pixel_offset: expected %h, got %h", want.off, o_pixel_offset);
                    err_cnt++;
                end
                if (o_row_end !== want.rend) begin
                    $error("row_end: expected %b, got %b", want.rend, o_row_end);
                    err_cnt++;
                end
                if (o_rect_end !== want.xend) begin
                    $error("rect_end: expected %b, got %b", want.xend, o_rect_end);
                    err_cnt++;
                end
                checked_cnt++;
                row_ends += int'(want.rend);
                rect_ends += int'(want.xend);
            end
        end
    end

    task automatic send_pixel(input logic [7:0] cov, input logic [31:0] old, input bit typed,
                              input t_blend_out typed_res);
        t_blend_out res;
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_coverage <= cov;
        i_old_pixel <= old;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        res = blend_at_cursor(cov, old);
        due_pixels.push_back(typed ? typed_res : res);
        sent_cnt++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (due_pixels.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [gcb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_reg(idx, data);
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic t_stim_row cfg_row(input logic [gcb_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [31:0] data);
        return '{kind: ROW_CFG, index: idx, data: data, cov: '0, res: '0};
    endfunction

    function automatic t_stim_row pix_row(input logic [7:0] cov, input logic [31:0] old);
        return '{kind: ROW_PIX, index: '0, data: old, cov: cov, res: '0};
    endfunction

    function automatic t_stim_row typed_row(input logic [7:0] cov, input logic [31:0] old,
                                            input logic [31:0] px, input logic [31:0] off,
                                            input logic rend, input logic xend);
        t_blend_out r;
        r = '{px: px, off: off, rend: rend, xend: xend};
        return '{kind: ROW_PIX_TYPED, index: '0, data: old, cov: cov, res: r};
    endfunction

    function automatic logic [gcb_pkg::DIM_W-1:0] pick_size();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return gcb_pkg::DIM_W'(gcb_pkg::MAX_DIM);
            2: return '1;
            3: return gcb_pkg::DIM_W'($urandom_range(gcb_pkg::MAX_DIM + 1, 8191));
            4: return gcb_pkg::DIM_W'($urandom);
            default: return gcb_pkg::DIM_W'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic logic [31:0] pick_color();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return {8'h00, 24'($urandom)};
            3: return {8'hFF, 24'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic random_setup();
        logic [15:0] pitch;
        if ($urandom_range(0, 3) != 0) begin
            write_reg(gcb_pkg::REG_FILL_COLOR, pick_color());
        end
        if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 3))
                0: pitch = '0;
                1: pitch = '1;
                default: pitch = 16'($urandom);
            endcase
            write_reg(gcb_pkg::REG_ROW_PITCH, {16'($urandom), pitch});
        end
        if ($urandom_range(0, 3) != 0) begin
            write_reg(gcb_pkg::REG_RECT_WIDTH, ($urandom & ~32'h1FFF) | 32'(pick_size()));
        end
        if ($urandom_range(0, 3) != 0) begin
            write_reg(gcb_pkg::REG_RECT_HEIGHT, ($urandom & ~32'h1FFF) | 32'(pick_size()));
        end
        if ($urandom_range(0, 2) != 0) begin
            write_reg(gcb_pkg::REG_BLEND_MODE, $urandom);
        end
        if ($urandom_range(0, 7) == 0) begin
            write_reg(gcb_pkg::CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                      $urandom);
        end
    endtask

    task automatic random_pixel();
        logic [7:0]  cov;
        logic [31:0] old;
        case ($urandom_range(0, 9))
            0: cov = '0;
            1: cov = '1;
            default: cov = 8'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0: old = '0;
            1: old = '1;
            default: old = $urandom;
        endcase
        send_pixel(cov, old, 1'b0, '0);
    endtask

    initial begin
        int in_pct[3];
        int out_pct[3];
        int phase_start;
        int seg_len;
        t_stim_row r;

        in_pct = '{33, 83, 0};
        out_pct = '{83, 33, 0};
        i_rst_n <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_coverage <= '0;
        i_old_pixel <= '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        dir_rows.push_back(typed_row(8'h00, 32'hFFFFFFFF, 32'h00FFFFFF, 32'h0, 1'b1, 1'b1));
        dir_rows.push_back(pix_row(8'hFF, 32'h12345678));
        dir_rows.push_back(cfg_row(gcb_pkg::REG_FILL_COLOR, 32'hFFFFFFFF));
        dir_rows.push_back(cfg_row(gcb_pkg::REG_ROW_PITCH, 32'h0000FFFF));
        dir_rows.push_back(cfg_row(gcb_pkg::REG_RECT_WIDTH, 32'd2));
        dir_rows.push_back(cfg_row(gcb_pkg::REG_RECT_HEIGHT, 32'd2));
        dir_rows.push_back(typed_row(8'h00, 32'h00000000, 32'hFF000000, 32'h0, 1'b0, 1'b0));
        dir_rows.push_back(pix_row(8'hFF, 32'h00000000));
        dir_rows.push_back(pix_row(8'h80, 32'h80808080));
        dir_rows.push_back(pix_row(8'h01, 32'hFFFFFFFF));
        dir_rows.push_back(cfg_row(gcb_pkg::REG_BLEND_MODE, 32'd1));
        dir_rows.push_back(typed_row(8'hFF, 32'h00000000, 32'hFFFFFFFF, 32'h0, 1'b0, 1'b0));
        dir_rows.push_back(typed_row(8'h00, 32'h00000000, 32'h00000000, 32'h4, 1'b1, 1'b0));
        dir_rows.push_back(cfg_row(gcb_pkg::REG_RECT_WIDTH, 32'd0));
        dir_rows.push_back(typed_row(8'h00, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFF, 1'b1, 1'b1));
        dir_rows.push_back(cfg_row(gcb_pkg::REG_RECT_WIDTH, 32'h00001FFF));
        dir_rows.push_back(cfg_row(gcb_pkg::REG_RECT_HEIGHT, 32'd0));
        dir_rows.push_back(pix_row(8'h01, 32'h5A5AA5A5));
        dir_rows.push_back(pix_row(8'hFE, 32'hA5A55A5A));
        dir_rows.push_back(cfg_row(gcb_pkg::REG_RECT_WIDTH, 32'd1));
        dir_rows.push_back(pix_row(8'h80, 32'h00FF00FF));
        dir_rows.push_back(cfg_row(REG_SPARE_LO, 32'hFFFFFFFF));
        dir_rows.push_back(cfg_row(REG_SPARE_HI, 32'h00000000));
        dir_rows.push_back(cfg_row(gcb_pkg::REG_BLEND_MODE, 32'd0));
        dir_rows.push_back(pix_row(8'hFF, 32'hFF00FF00));

        for (int ph = 0; ph < 3; ph++) begin
            in_idle_pct = in_pct[ph];
            out_idle_pct = out_pct[ph];
            phase_start = sent_cnt;
            if (ph == 0) begin
                foreach (dir_rows[i]) begin
                    r = dir_rows[i];
                    if (r.kind == ROW_CFG) begin
                        wait_drained();
                        write_reg(r.index, r.data);
                    end else begin
                        send_pixel(r.cov, r.data, r.kind == ROW_PIX_TYPED, r.res);
                    end
                end
            end
            while (sent_cnt - phase_start < PHASE_WORDS) begin
                wait_drained();
                random_setup();
                seg_len = $urandom_range(20, 120);
                for (int n = 0; n < seg_len; n++) begin
                    random_pixel();
                    if ($urandom_range(0, 149) == 0) begin
                        wait_drained();
                    end
                end
            end
        end

        wait_drained();
        repeat (10) @(negedge i_clk);
        if (due_pixels.size() != 0) begin
            $error("%0d words never arrived", due_pixels.size());
            err_cnt++;
        end
        $display("Sent %0d pixels in both blend modes with %0d register writes under three",
                 sent_cnt, reg_writes);
        $display("flow-control phases; checked %0d words, %0d row ends, %0d rectangle ends.",
                 checked_cnt, row_ends, rect_ends);
        if (err_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
